// ===== rtl/mssq_pkg.sv =====
// ----------------------------------------------------------------------------
// mssq_pkg
// Types and constants shared by the stepper position sequencer modules.
// ----------------------------------------------------------------------------
package mssq_pkg;

  localparam int MAX_LANES  = 4;    // masks and enable register are 4 bits wide
  localparam int POS_W      = 32;
  localparam int IVL_W      = 20;
  localparam int MASK_W     = 4;

  typedef logic [1:0]       kind_t;
  typedef logic [1:0]       motor_idx_t;
  typedef logic [1:0]       cfg_index_t;
  typedef logic [IVL_W-1:0] interval_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [MASK_W-1:0] mask_t;

  localparam kind_t KIND_SET_TARGET = 2'd0;
  localparam kind_t KIND_TICK       = 2'd1;
  localparam kind_t KIND_STOP_ALL   = 2'd2;

  localparam cfg_index_t CFG_ENABLE_MASK  = 2'd0;
  localparam cfg_index_t CFG_MIN_INTERVAL = 2'd1;
  localparam cfg_index_t CFG_MAX_INTERVAL = 2'd2;

  localparam mask_t     RESET_ENABLE_MASK  = 4'd0;
  localparam interval_t RESET_MIN_INTERVAL = 20'd100;
  localparam interval_t RESET_MAX_INTERVAL = 20'd20000;
  localparam interval_t RESET_INTERVAL     = 20'd5000;

  // Item in the input register, broadcast to every motor lane
  typedef struct packed {
    logic       fire;       // item leaves the input register this cycle
    kind_t      kind;
    motor_idx_t motor_index;
    pos_t       target;
    logic       req_nonzero;
    interval_t  interval;   // request already clamped to the limits
    mask_t      enable_mask;
  } item_ctrl_t;

  // Per-motor state as it stands after the item has acted
  typedef struct packed {
    logic      step;
    logic      reverse;
    logic      active;
    interval_t interval;
    pos_t      position;
  } lane_out_t;

  typedef struct packed {
    mask_t     step_mask;
    mask_t     direction_mask;
    mask_t     finished_mask;
    interval_t timer_period;
    logic      timer_running;
    pos_t      position_readout;
  } summary_t;

endpackage

// ===== rtl/multi_stepper_position_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// multi_stepper_position_sequencer_core
// Step/direction sequencer for up to four stepper motors.
//
// Input stream (s_*): one item per command. tuser carries the kind (set
// target, tick, stop all); tdata carries motor index, target position and
// requested interval. Output stream (m_*): one result per input item with
// step, direction and finished masks, timer period, running flag and the
// position of the addressed motor, taken after the item has acted.
// Configuration (cfg_*): enable mask, minimum and maximum interval; the user
// must see that they are written only while the streams are idle, as the
// block does not enforce it. An accepted item lands in an input register;
// from there the lane update and summary are loaded into the output register.
// Throughput is one item per cycle while the receiver does not stall; the
// motor lanes, up to four, update in parallel.
// Reset clears all positions and counts, sets every interval to 5000 us and
// loads the register defaults. When the receiver stalls, the result holds in
// the output register and one further item waits in the input register;
// s_tready then drops until the result is taken.
// ----------------------------------------------------------------------------
module multi_stepper_position_sequencer_core #(
  parameter int NUM_MOTORS = 4
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_wdata,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // [1:0] motor_index, [33:2] target_position,
                                 // [53:34] interval_request, [55:54] zero
  input  logic [1:0]  s_tuser,   // [1:0] kind
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // [3:0] step_mask, [7:4] direction_mask,
                                 // [11:8] finished_mask, [31:12] timer_period,
                                 // [32] timer_running, [64:33] position_readout,
                                 // [71:65] zero
);
  import mssq_pkg::*;

  localparam int NACT = (NUM_MOTORS < MAX_LANES) ? NUM_MOTORS : MAX_LANES;

  mask_t     enable_mask;
  interval_t min_interval;
  interval_t max_interval;

  logic       in_valid;
  kind_t      in_kind;
  motor_idx_t in_index;
  pos_t       in_target;
  interval_t  in_request;

  logic       advance;
  logic       fire;
  interval_t  clamped;
  item_ctrl_t ctrl;
  lane_out_t  lanes [NACT];
  summary_t   summary;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask  <= RESET_ENABLE_MASK;
      min_interval <= RESET_MIN_INTERVAL;
      max_interval <= RESET_MAX_INTERVAL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE_MASK:  enable_mask  <= cfg_wdata[MASK_W-1:0];
        CFG_MIN_INTERVAL: min_interval <= cfg_wdata;
        CFG_MAX_INTERVAL: max_interval <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind    <= s_tuser;
      in_index   <= s_tdata[1:0];
      in_target  <= s_tdata[33:2];
      in_request <= s_tdata[53:34];
    end
  end

  // min checked first: crossed limits give min below min_interval, else max
  always_comb begin
    if (in_request < min_interval) begin
      clamped = min_interval;
    end else if (in_request > max_interval) begin
      clamped = max_interval;
    end else begin
      clamped = in_request;
    end
  end

  assign ctrl.fire        = fire;
  assign ctrl.kind        = in_kind;
  assign ctrl.motor_index = in_index;
  assign ctrl.target      = in_target;
  assign ctrl.req_nonzero = (in_request != '0);
  assign ctrl.interval    = clamped;
  assign ctrl.enable_mask = enable_mask;

  for (genvar g = 0; g < NACT; g++) begin : g_lane
    mssq_lane #(
      .LANE (g)
    ) u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl),
      .lane (lanes[g])
    );
  end

  mssq_summary #(
    .NACT (NACT)
  ) u_summary (
    .lanes       (lanes),
    .motor_index (in_index),
    .summary     (summary)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {7'd0,
                  summary.position_readout,
                  summary.timer_running,
                  summary.timer_period,
                  summary.finished_mask,
                  summary.direction_mask,
                  summary.step_mask};
    end
  end

endmodule

// ===== rtl/mssq_lane.sv =====
// ----------------------------------------------------------------------------
// mssq_lane
// State of one motor: position, steps left, direction and step interval,
// with the next-state logic for set target, tick and stop all.
// ----------------------------------------------------------------------------
module mssq_lane #(
  parameter int LANE = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mssq_pkg::item_ctrl_t    ctrl,
  output mssq_pkg::lane_out_t     lane
);
  import mssq_pkg::*;

  pos_t      position, position_next;
  pos_t      steps_left, steps_left_next;
  logic      reverse, reverse_next;
  interval_t step_interval, step_interval_next;

  logic        enabled;
  logic        selected;
  logic [32:0] diff;
  logic [32:0] diff_neg;
  logic        step;

  assign enabled  = ctrl.enable_mask[LANE];
  assign selected = enabled && (ctrl.motor_index == 2'(LANE));
  // target - position at 33 bits, both sign-extended
  assign diff     = {ctrl.target[POS_W-1], ctrl.target} - {position[POS_W-1], position};
  assign diff_neg = ~diff + 33'd1;

  always_comb begin
    position_next      = position;
    steps_left_next    = steps_left;
    reverse_next       = reverse;
    step_interval_next = step_interval;
    step               = 1'b0;
    case (ctrl.kind)
      KIND_SET_TARGET: begin
        if (selected) begin
          if (ctrl.req_nonzero) begin
            step_interval_next = ctrl.interval;
          end
          reverse_next    = diff[32];
          steps_left_next = diff[32] ? diff_neg[POS_W-1:0] : diff[POS_W-1:0];
        end
      end
      KIND_TICK: begin
        if (enabled && steps_left != '0) begin
          step            = 1'b1;
          position_next   = reverse ? position - 32'd1 : position + 32'd1;
          steps_left_next = steps_left - 32'd1;
        end
      end
      KIND_STOP_ALL: begin
        steps_left_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      steps_left    <= '0;
      reverse       <= 1'b0;
      step_interval <= RESET_INTERVAL;
    end else if (ctrl.fire) begin
      position      <= position_next;
      steps_left    <= steps_left_next;
      reverse       <= reverse_next;
      step_interval <= step_interval_next;
    end
  end

  assign lane.step     = step;
  assign lane.reverse  = reverse_next;
  assign lane.active   = enabled && (steps_left_next != '0);
  assign lane.interval = step_interval_next;
  assign lane.position = position_next;

endmodule

// ===== rtl/mssq_summary.sv =====
// ----------------------------------------------------------------------------
// mssq_summary
// Folds the lane states into the result: masks, shortest active interval,
// running flag and the position of the addressed motor.
// ----------------------------------------------------------------------------
module mssq_summary #(
  parameter int NACT = 4
) (
  input  mssq_pkg::lane_out_t  lanes [NACT],
  input  mssq_pkg::motor_idx_t motor_index,
  output mssq_pkg::summary_t   summary
);
  import mssq_pkg::*;

  always_comb begin
    summary = '0;
    for (int i = 0; i < NACT; i++) begin
      summary.step_mask[i]      = lanes[i].step;
      summary.direction_mask[i] = lanes[i].reverse;
      summary.finished_mask[i]  = !lanes[i].active;
      // first active motor seeds the minimum
      if (lanes[i].active &&
          (!summary.timer_running || lanes[i].interval < summary.timer_period)) begin
        summary.timer_period  = lanes[i].interval;
        summary.timer_running = 1'b1;
      end
      // index beyond the motors present leaves the readout at zero
      if (motor_index == 2'(i)) begin
        summary.position_readout = lanes[i].position;
      end
    end
  end

endmodule
